// File: rtl/plc_pkg.sv
// plc_pkg: shared types, constants and helpers for the point leader clustering block
// no dependencies; used by plc_dist, plc_div and the top level
package plc_pkg;

  localparam int CoordBits   = 16;
  localparam int FracBits    = 8;
  localparam int MeanBits    = CoordBits + FracBits;
  localparam int CountBits   = 16;
  localparam int LimitBits   = 32;
  localparam int DivBits     = MeanBits + 1;
  localparam int DivisorBits = CountBits + 1;
  localparam int SqBits      = 2 * (CoordBits + 1);
  localparam int SumBits     = SqBits + 2;
  localparam int SlotBits    = 6;
  localparam int TotalBits   = 7;
  localparam int PartBits    = 3;
  localparam logic [LimitBits-1:0] LimitReset = 32'd400000;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [PartBits-1:0] {
    PART_MEAN   = 3'd0,
    PART_LEFT   = 3'd1,
    PART_RIGHT  = 3'd2,
    PART_TOP    = 3'd3,
    PART_BOTTOM = 3'd4
  } part_e;

  typedef enum logic [0:0] {
    CFG_EDGE_LIMIT     = 1'b0,
    CFG_CENTROID_LIMIT = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_REQ,
    ST_RD_LATCH,
    ST_DIST,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_UPDATE,
    ST_NEW,
    ST_FINISH
  } state_e;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [MeanBits-1:0]  mean_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic [CountBits-1:0] count;
    mean_t  mean_x;
    mean_t  mean_y;
    mean_t  mean_z;
    point_t last;
    point_t left;
    point_t right;
    point_t low;
    point_t high;
  } rec_t;

  typedef struct packed {
    action_e              action;
    coord_t               point_x;
    coord_t               point_y;
    coord_t               point_z;
    logic [SlotBits-1:0]  read_index;
    logic [PartBits-1:0]  read_part;
  } in_t;

  typedef struct packed {
    logic [SlotBits-1:0]  slot;
    logic                 opened_new;
    logic                 dropped_full;
    logic [TotalBits-1:0] cluster_total;
    logic [CountBits-1:0] member_count;
    coord_t               out_x;
    coord_t               out_y;
    coord_t               out_z;
  } out_t;

  // record of a freshly cleared slot 0
  function automatic rec_t reset_rec();
    rec_t r;
    r = '0;
    r.count = CountBits'(1);
    return r;
  endfunction

  // floor of a mean with fraction bits to whole millimetres
  function automatic coord_t floor_mean(mean_t m);
    return m[MeanBits-1:FracBits];
  endfunction

endpackage

// File: rtl/plc_ram.sv
// plc_ram: generic single-write, single-read memory with registered read data
// no dependencies
module plc_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/plc_dist.sv
// plc_dist: shared squared-distance unit, squares registered, sum after the register
// depends on plc_pkg
module plc_dist (
  input  logic                         clk_i,
  input  plc_pkg::point_t              a_i,
  input  plc_pkg::point_t              b_i,
  output logic [plc_pkg::SumBits-1:0]  sum_o
);

  localparam int DW = plc_pkg::CoordBits + 1;
  localparam int SW = plc_pkg::SqBits;

  logic signed [DW-1:0] dx, dy, dz;
  logic signed [2*DW-1:0] px, py, pz;
  logic [SW-1:0] sqx_q, sqy_q, sqz_q;

  // per-axis differences and squares
  always_comb begin
    dx = DW'(a_i.x) - DW'(b_i.x);
    dy = DW'(a_i.y) - DW'(b_i.y);
    dz = DW'(a_i.z) - DW'(b_i.z);
    px = dx * dx;
    py = dy * dy;
    pz = dz * dz;
  end

  always_ff @(posedge clk_i) begin
    sqx_q <= px[SW-1:0];
    sqy_q <= py[SW-1:0];
    sqz_q <= pz[SW-1:0];
  end

  // sum of the three squares
  assign sum_o = plc_pkg::SumBits'(sqx_q) + plc_pkg::SumBits'(sqy_q)
               + plc_pkg::SumBits'(sqz_q);

endmodule

// File: rtl/plc_div.sv
// plc_div: radix-2 restoring divider, signed dividend, unsigned divisor, truncating
// depends on plc_pkg
module plc_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [plc_pkg::DivBits-1:0]  dividend_i,
  input  logic [plc_pkg::DivisorBits-1:0]     divisor_i,
  output logic                                done_o,
  output logic signed [plc_pkg::DivBits-1:0]  quot_o
);

  localparam int NW = plc_pkg::DivBits;
  localparam int RW = plc_pkg::DivisorBits;
  localparam int CW = $clog2(NW + 1);

  logic          busy_q, done_q, neg_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] num_q;
  logic [RW-1:0] rem_q;
  logic [RW-1:0] dsr_q;
  logic [RW:0]   trial;
  logic          qbit;

  // one quotient bit per cycle
  always_comb begin
    trial = {rem_q, num_q[NW-1]};
    qbit  = (trial >= {1'b0, dsr_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[NW-1];
      num_q <= dividend_i[NW-1] ? NW'(-dividend_i) : NW'(dividend_i);
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= qbit ? RW'(trial - {1'b0, dsr_q}) : RW'(trial);
      num_q <= {num_q[NW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(num_q) : $signed(num_q);

endmodule

// File: rtl/point_leader_clustering.sv
// point_leader_clustering: top level, sequencer, cluster table and result register
// depends on plc_pkg, plc_ram, plc_dist, plc_div
//
//  channel | direction | signals                              | beat
//  in      | input     | in_valid_i, in_stall_o, in_data_i    | valid & !stall
//  out     | output    | out_valid_o, out_stall_i, out_data_o | valid & !stall
//  cfg     | input     | cfg_we_i, cfg_idx_i, cfg_wdata_i     | we
//
// start frame and idle action go straight to the result; read: a memory read, or straight
// to the result for a slot not in use. add point: take the beat, then per table slot scanned
// a memory read and 4 distance checks through the one squared-distance unit, then on a join
// the serial mean divider for each axis before the table write, or a slot is opened or the
// point dropped.
// reset and start frame need no clearing pass: slot 0 reads as its cleared record
// until first written. a result waits in the output register while out is stalled.
module point_leader_clustering #(
  parameter int MAX_CLUSTERS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  plc_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output plc_pkg::out_t                       out_data_o,
  input  logic                                cfg_we_i,
  input  plc_pkg::cfg_reg_e                   cfg_idx_i,
  input  logic [plc_pkg::LimitBits-1:0]       cfg_wdata_i
);

  localparam int SlotW  = $clog2(MAX_CLUSTERS);
  localparam int ActW   = $clog2(MAX_CLUSTERS + 1);
  localparam int IdxW   = (ActW > plc_pkg::SlotBits) ? ActW : plc_pkg::SlotBits;
  localparam int RecW   = $bits(plc_pkg::rec_t);
  localparam int SlotOW = plc_pkg::SlotBits;
  localparam int TotW   = plc_pkg::TotalBits;
  localparam int DivW   = plc_pkg::DivBits;
  localparam int MeanW  = plc_pkg::MeanBits;
  localparam int CntW   = plc_pkg::CountBits;
  localparam int SumW   = plc_pkg::SumBits;

  plc_pkg::state_e state_q, state_d;

  logic [plc_pkg::LimitBits-1:0] edge_lim_q, cent_lim_q;
  logic [ActW-1:0]  active_q;
  logic             fresh0_q;
  logic [SlotW-1:0] slot_q;
  logic [2:0]       step_q;
  logic             hit_q;
  logic [1:0]       axis_q;
  plc_pkg::in_t     in_q;
  plc_pkg::rec_t    rec_q;
  plc_pkg::mean_t   mx_q, my_q, mz_q;
  plc_pkg::out_t    res_q, out_q;
  logic             out_valid_q;

  logic             in_acc, out_free, load_out;
  logic             ram_re, ram_we;
  logic [SlotW-1:0] rd_addr, wr_addr;
  logic [RecW-1:0]  ram_rdata;
  plc_pkg::rec_t    rec_rd, wr_rec, upd_rec, new_rec;
  logic [IdxW-1:0]  in_idx_w;
  logic             in_idx_oor;
  logic [ActW-1:0]  slot_next;
  logic             full;
  plc_pkg::point_t  p_in;
  plc_pkg::point_t  dist_a;
  logic [SumW-1:0]  dist_sum;
  logic             hit_now;
  logic             div_start, div_done;
  logic signed [DivW-1:0] dividend, quot;
  plc_pkg::mean_t   cur_mean, pm;
  logic [plc_pkg::DivisorBits-1:0] divisor;

  assign in_stall_o = (state_q != plc_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign p_in = '{x: in_q.point_x, y: in_q.point_y, z: in_q.point_z};

  // read index range check on the incoming beat
  assign in_idx_w   = IdxW'(in_data_i.read_index);
  assign in_idx_oor = (in_idx_w >= IdxW'(active_q));

  assign slot_next = ActW'(slot_q) + ActW'(1);
  assign full      = (active_q >= ActW'(MAX_CLUSTERS));

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_lim_q <= plc_pkg::LimitReset;
      cent_lim_q <= plc_pkg::LimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        plc_pkg::CFG_EDGE_LIMIT:     edge_lim_q <= cfg_wdata_i;
        plc_pkg::CFG_CENTROID_LIMIT: cent_lim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // cluster table
  assign rd_addr = (in_q.action == plc_pkg::ACT_READ) ? SlotW'(in_q.read_index) : slot_q;

  plc_ram #(
    .Width (RecW),
    .Depth (MAX_CLUSTERS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_rec),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // slot 0 reads as cleared until written after reset or start frame
  assign rec_rd = (fresh0_q && rd_addr == '0) ? plc_pkg::reset_rec() : plc_pkg::rec_t'(ram_rdata);

  // shared distance unit, reference point picked by step
  always_comb begin
    case (step_q)
      3'd0:    dist_a = rec_q.last;
      3'd1:    dist_a = rec_q.left;
      3'd2:    dist_a = rec_q.right;
      default: dist_a = '{x: plc_pkg::floor_mean(rec_q.mean_x),
                          y: plc_pkg::floor_mean(rec_q.mean_y),
                          z: plc_pkg::floor_mean(rec_q.mean_z)};
    endcase
  end

  plc_dist u_dist (
    .clk_i (clk_i),
    .a_i   (dist_a),
    .b_i   (p_in),
    .sum_o (dist_sum)
  );

  // sum on the bus belongs to the previous step; step 4 checks the mean
  assign hit_now = (step_q == 3'd4) ? (dist_sum < SumW'(cent_lim_q))
                                    : (dist_sum < SumW'(edge_lim_q));

  // mean divider operands
  always_comb begin
    case (axis_q)
      2'd0:    begin cur_mean = rec_q.mean_x; pm = {in_q.point_x, 8'h00}; end
      2'd1:    begin cur_mean = rec_q.mean_y; pm = {in_q.point_y, 8'h00}; end
      default: begin cur_mean = rec_q.mean_z; pm = {in_q.point_z, 8'h00}; end
    endcase
    dividend = DivW'(pm) - DivW'(cur_mean);
    divisor  = plc_pkg::DivisorBits'(rec_q.count) + plc_pkg::DivisorBits'(1);
  end

  plc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // joined and opened records
  always_comb begin
    upd_rec        = rec_q;
    upd_rec.count  = (rec_q.count == '1) ? rec_q.count : rec_q.count + CntW'(1);
    upd_rec.mean_x = mx_q;
    upd_rec.mean_y = my_q;
    upd_rec.mean_z = mz_q;
    upd_rec.last   = p_in;
    if ($signed(rec_q.left.y) >= $signed(p_in.y))  upd_rec.left  = p_in;
    if ($signed(rec_q.right.y) <= $signed(p_in.y)) upd_rec.right = p_in;
    if ($signed(rec_q.low.z) > $signed(p_in.z))    upd_rec.low   = p_in;
    if ($signed(rec_q.high.z) < $signed(p_in.z))   upd_rec.high  = p_in;

    new_rec        = '0;
    new_rec.count  = CntW'(1);
    new_rec.mean_x = {in_q.point_x, 8'h00};
    new_rec.mean_y = {in_q.point_y, 8'h00};
    new_rec.mean_z = {in_q.point_z, 8'h00};
    new_rec.last   = p_in;
    new_rec.left   = p_in;
    new_rec.right  = p_in;
    new_rec.low    = p_in;
    new_rec.high   = p_in;
  end

  assign wr_rec  = (state_q == plc_pkg::ST_UPDATE) ? upd_rec : new_rec;
  assign wr_addr = (state_q == plc_pkg::ST_UPDATE) ? slot_q : active_q[SlotW-1:0];

  // sequencer next state
  always_comb begin
    state_d   = state_q;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      plc_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.action)
            plc_pkg::ACT_ADD:  state_d = plc_pkg::ST_RD_REQ;
            plc_pkg::ACT_READ: state_d = in_idx_oor ? plc_pkg::ST_FINISH
                                                    : plc_pkg::ST_RD_REQ;
            default:           state_d = plc_pkg::ST_FINISH;
          endcase
        end
      end
      plc_pkg::ST_RD_REQ: begin
        ram_re  = 1'b1;
        state_d = plc_pkg::ST_RD_LATCH;
      end
      plc_pkg::ST_RD_LATCH: begin
        state_d = (in_q.action == plc_pkg::ACT_READ) ? plc_pkg::ST_FINISH
                                                     : plc_pkg::ST_DIST;
      end
      plc_pkg::ST_DIST: begin
        if (step_q == 3'd4) begin
          if (hit_q || hit_now)         state_d = plc_pkg::ST_DIV_GO;
          else if (slot_next < active_q) state_d = plc_pkg::ST_RD_REQ;
          else                           state_d = plc_pkg::ST_NEW;
        end
      end
      plc_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = plc_pkg::ST_DIV_WAIT;
      end
      plc_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = (axis_q == 2'd2) ? plc_pkg::ST_UPDATE : plc_pkg::ST_DIV_GO;
        end
      end
      plc_pkg::ST_UPDATE: begin
        ram_we  = 1'b1;
        state_d = plc_pkg::ST_FINISH;
      end
      plc_pkg::ST_NEW: begin
        ram_we  = !full;
        state_d = plc_pkg::ST_FINISH;
      end
      plc_pkg::ST_FINISH: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = plc_pkg::ST_IDLE;
        end
      end
      default: state_d = plc_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plc_pkg::ST_IDLE;
      active_q    <= ActW'(1);
      fresh0_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && in_data_i.action == plc_pkg::ACT_START) begin
        active_q <= ActW'(1);
        fresh0_q <= 1'b1;
      end
      if (state_q == plc_pkg::ST_NEW && !full) begin
        active_q <= active_q + ActW'(1);
      end
      if (state_q == plc_pkg::ST_UPDATE && slot_q == '0) begin
        fresh0_q <= 1'b0;
      end
      if (load_out)            out_valid_q <= 1'b1;
      else if (!out_stall_i)   out_valid_q <= 1'b0;
    end
  end

  // working registers and result
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= res_q;
    end
    case (state_q)
      plc_pkg::ST_IDLE: begin
        if (in_acc) begin
          in_q   <= in_data_i;
          slot_q <= '0;
          res_q.slot          <= (in_data_i.action == plc_pkg::ACT_READ)
                                 ? in_data_i.read_index : '0;
          res_q.opened_new    <= 1'b0;
          res_q.dropped_full  <= 1'b0;
          res_q.cluster_total <= (in_data_i.action == plc_pkg::ACT_START)
                                 ? TotW'(1) : TotW'(active_q);
          res_q.member_count  <= (in_data_i.action == plc_pkg::ACT_START)
                                 ? CntW'(1) : '0;
          res_q.out_x         <= '0;
          res_q.out_y         <= '0;
          res_q.out_z         <= '0;
        end
      end
      plc_pkg::ST_RD_LATCH: begin
        rec_q  <= rec_rd;
        step_q <= 3'd0;
        hit_q  <= 1'b0;
        axis_q <= 2'd0;
        res_q.slot          <= in_q.read_index;
        res_q.cluster_total <= TotW'(active_q);
        res_q.member_count  <= rec_rd.count;
        case (in_q.read_part)
          plc_pkg::PART_MEAN: begin
            res_q.out_x <= plc_pkg::floor_mean(rec_rd.mean_x);
            res_q.out_y <= plc_pkg::floor_mean(rec_rd.mean_y);
            res_q.out_z <= plc_pkg::floor_mean(rec_rd.mean_z);
          end
          plc_pkg::PART_LEFT: begin
            res_q.out_x <= rec_rd.left.x;
            res_q.out_y <= rec_rd.left.y;
            res_q.out_z <= rec_rd.left.z;
          end
          plc_pkg::PART_RIGHT: begin
            res_q.out_x <= rec_rd.right.x;
            res_q.out_y <= rec_rd.right.y;
            res_q.out_z <= rec_rd.right.z;
          end
          plc_pkg::PART_TOP: begin
            res_q.out_x <= rec_rd.high.x;
            res_q.out_y <= rec_rd.high.y;
            res_q.out_z <= rec_rd.high.z;
          end
          plc_pkg::PART_BOTTOM: begin
            res_q.out_x <= rec_rd.low.x;
            res_q.out_y <= rec_rd.low.y;
            res_q.out_z <= rec_rd.low.z;
          end
          default: begin
            res_q.out_x <= '0;
            res_q.out_y <= '0;
            res_q.out_z <= '0;
          end
        endcase
      end
      plc_pkg::ST_DIST: begin
        step_q <= step_q + 3'd1;
        if (step_q != 3'd0) hit_q <= hit_q | hit_now;
        if (step_q == 3'd4 && !(hit_q || hit_now)) slot_q <= slot_q + SlotW'(1);
      end
      plc_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          axis_q <= axis_q + 2'd1;
          case (axis_q)
            2'd0:    mx_q <= cur_mean + MeanW'(quot);
            2'd1:    my_q <= cur_mean + MeanW'(quot);
            default: mz_q <= cur_mean + MeanW'(quot);
          endcase
        end
      end
      plc_pkg::ST_UPDATE: begin
        res_q.slot          <= SlotOW'(slot_q);
        res_q.opened_new    <= 1'b0;
        res_q.dropped_full  <= 1'b0;
        res_q.cluster_total <= TotW'(active_q);
        res_q.member_count  <= upd_rec.count;
        res_q.out_x         <= plc_pkg::floor_mean(mx_q);
        res_q.out_y         <= plc_pkg::floor_mean(my_q);
        res_q.out_z         <= plc_pkg::floor_mean(mz_q);
      end
      plc_pkg::ST_NEW: begin
        if (full) begin
          res_q.slot          <= '0;
          res_q.opened_new    <= 1'b0;
          res_q.dropped_full  <= 1'b1;
          res_q.cluster_total <= TotW'(active_q);
          res_q.member_count  <= '0;
          res_q.out_x         <= '0;
          res_q.out_y         <= '0;
          res_q.out_z         <= '0;
        end else begin
          res_q.slot          <= SlotOW'(active_q);
          res_q.opened_new    <= 1'b1;
          res_q.dropped_full  <= 1'b0;
          res_q.cluster_total <= TotW'(active_q + ActW'(1));
          res_q.member_count  <= CntW'(1);
          res_q.out_x         <= in_q.point_x;
          res_q.out_y         <= in_q.point_y;
          res_q.out_z         <= in_q.point_z;
        end
      end
      default: ;
    endcase
  end

  // table occupancy stays within bounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q != '0 && active_q <= ActW'(MAX_CLUSTERS))
    else $error("cluster count out of range");

  // a result never both opens and drops
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.opened_new && out_q.dropped_full))
    else $error("opened and dropped both set");

  // divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == plc_pkg::ST_DIV_WAIT)
    else $error("divider done outside wait state");

  // a table write never lands while a beat is being taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !in_acc)
    else $error("table write during input beat");

endmodule

// File: test/tb_top.sv
// tb_top: self-checking testbench for point_leader_clustering
// depends on plc_pkg and the rtl top level; holds its own cluster-table predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int Slots      = 64;
  localparam int CycleLimit = 4000000;
  localparam int SlotW      = plc_pkg::SlotBits;
  localparam int PartW      = plc_pkg::PartBits;
  localparam int TotW       = plc_pkg::TotalBits;
  localparam int CntW       = plc_pkg::CountBits;
  localparam int InW        = $bits(plc_pkg::in_t);

  // predicts each result beat from the accepted input beats
  class cluster_sb;
    plc_pkg::out_t    want_q[$];
    int               errors;
    longint           edge_lim, cent_lim;
    int               total;
    int               cnt[Slots];
    longint           mx[Slots], my[Slots], mz[Slots];
    plc_pkg::point_t  lastp[Slots], leftp[Slots], rightp[Slots], lowp[Slots], highp[Slots];

    function new();
      errors   = 0;
      edge_lim = 400000;
      cent_lim = 400000;
      clear_table();
    endfunction

    function void clear_table();
      total = 1;
      for (int s = 0; s < Slots; s++) begin
        cnt[s] = 0;
        mx[s] = 0; my[s] = 0; mz[s] = 0;
        lastp[s] = '0; leftp[s] = '0; rightp[s] = '0; lowp[s] = '0; highp[s] = '0;
      end
      cnt[0] = 1;
    endfunction

    function void set_limit(plc_pkg::cfg_reg_e idx, logic [31:0] v);
      if (idx == plc_pkg::CFG_EDGE_LIMIT) edge_lim = longint'(v);
      else cent_lim = longint'(v);
    endfunction

    function longint sq_gap(plc_pkg::point_t a, plc_pkg::point_t b);
      longint dx, dy, dz;
      dx = longint'($signed(a.x)) - longint'($signed(b.x));
      dy = longint'($signed(a.y)) - longint'($signed(b.y));
      dz = longint'($signed(a.z)) - longint'($signed(b.z));
      return dx * dx + dy * dy + dz * dz;
    endfunction

    // mean floored to whole mm
    function plc_pkg::point_t mean_mm(int s);
      plc_pkg::point_t r;
      r.x = plc_pkg::coord_t'(mx[s] >>> 8);
      r.y = plc_pkg::coord_t'(my[s] >>> 8);
      r.z = plc_pkg::coord_t'(mz[s] >>> 8);
      return r;
    endfunction

    function void note_input(plc_pkg::in_t it);
      plc_pkg::out_t   o;
      plc_pkg::point_t p, r;
      int     s, hit_slot;
      longint dv;
      o = '0;
      case (it.action)
        plc_pkg::ACT_START: begin
          clear_table();
          o.member_count = CntW'(1);
        end
        plc_pkg::ACT_READ: begin
          s = int'(it.read_index);
          o.slot = it.read_index;
          if (s < total) begin
            r = '0;
            case (it.read_part)
              plc_pkg::PART_MEAN:   r = mean_mm(s);
              plc_pkg::PART_LEFT:   r = leftp[s];
              plc_pkg::PART_RIGHT:  r = rightp[s];
              plc_pkg::PART_TOP:    r = highp[s];
              plc_pkg::PART_BOTTOM: r = lowp[s];
              default:              r = '0;
            endcase
            o.member_count = CntW'(cnt[s]);
            o.out_x = r.x; o.out_y = r.y; o.out_z = r.z;
          end
        end
        plc_pkg::ACT_ADD: begin
          p.x = it.point_x; p.y = it.point_y; p.z = it.point_z;
          hit_slot = -1;
          for (s = 0; s < total && hit_slot < 0; s++) begin
            if (sq_gap(lastp[s], p) < edge_lim || sq_gap(leftp[s], p) < edge_lim ||
                sq_gap(rightp[s], p) < edge_lim || sq_gap(mean_mm(s), p) < cent_lim)
              hit_slot = s;
          end
          if (hit_slot >= 0) begin
            s  = hit_slot;
            dv = longint'(cnt[s]) + 1;
            mx[s] += (longint'($signed(p.x)) * 256 - mx[s]) / dv;
            my[s] += (longint'($signed(p.y)) * 256 - my[s]) / dv;
            mz[s] += (longint'($signed(p.z)) * 256 - mz[s]) / dv;
            if (cnt[s] < 65535) cnt[s]++;
            lastp[s] = p;
            if ($signed(leftp[s].y) >= $signed(p.y)) leftp[s] = p;
            if ($signed(rightp[s].y) <= $signed(p.y)) rightp[s] = p;
            if ($signed(lowp[s].z) > $signed(p.z)) lowp[s] = p;
            if ($signed(highp[s].z) < $signed(p.z)) highp[s] = p;
            r = mean_mm(s);
            o.slot = SlotW'(s);
            o.member_count = CntW'(cnt[s]);
            o.out_x = r.x; o.out_y = r.y; o.out_z = r.z;
          end else if (total >= Slots) begin
            o.dropped_full = 1'b1;
          end else begin
            s = total;
            cnt[s] = 1;
            mx[s] = longint'($signed(p.x)) * 256;
            my[s] = longint'($signed(p.y)) * 256;
            mz[s] = longint'($signed(p.z)) * 256;
            lastp[s] = p; leftp[s] = p; rightp[s] = p; lowp[s] = p; highp[s] = p;
            total++;
            o.slot = SlotW'(s);
            o.opened_new = 1'b1;
            o.member_count = CntW'(1);
            o.out_x = p.x; o.out_y = p.y; o.out_z = p.z;
          end
        end
        default: ;
      endcase
      o.cluster_total = TotW'(total);
      want_q = {want_q, o};
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        $error("%s mismatch: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(plc_pkg::out_t got);
      plc_pkg::out_t e;
      if (want_q.size() == 0) begin
        $error("result beat with nothing expected: slot %0d", got.slot);
        errors++;
        return;
      end
      e = want_q.pop_front();
      cmp("slot", e.slot, got.slot);
      cmp("opened_new", e.opened_new, got.opened_new);
      cmp("dropped_full", e.dropped_full, got.dropped_full);
      cmp("cluster_total", e.cluster_total, got.cluster_total);
      cmp("member_count", e.member_count, got.member_count);
      cmp("out_x", $signed(e.out_x), $signed(got.out_x));
      cmp("out_y", $signed(e.out_y), $signed(got.out_y));
      cmp("out_z", $signed(e.out_z), $signed(got.out_z));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  plc_pkg::in_t        in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  plc_pkg::out_t       out_data_o;
  logic                cfg_we_i = 1'b0;
  plc_pkg::cfg_reg_e   cfg_idx_i = plc_pkg::CFG_EDGE_LIMIT;
  logic [31:0]         cfg_wdata_i = '0;

  cluster_sb        sb = new();
  bit               idle_on = 1'b1;
  bit               hold_req = 1'b0;
  int               cycles = 0;
  plc_pkg::point_t  centers[6];

  point_leader_clustering dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // receiver stalls, with one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        repeat (3000) @(negedge clk_i) out_stall_i <= 1'b1;
        hold_req = 1'b0;
      end
      n = idle_on ? $urandom_range(0, 19) : 0;
      repeat (n) @(negedge clk_i) out_stall_i <= 1'b1;
      @(negedge clk_i) out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // one input beat, after a random gap when idle_on is set
  task automatic send(plc_pkg::in_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    repeat (gap) @(negedge clk_i) in_valid_i <= 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
  endtask

  task automatic drain();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_cfg(plc_pkg::cfg_reg_e idx, logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= v;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    sb.set_limit(idx, v);
  endtask

  function automatic plc_pkg::coord_t clampc(int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return plc_pkg::coord_t'(v);
  endfunction

  // signed offset in [-spread, spread]
  function automatic int jit(int spread);
    return int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  function automatic plc_pkg::in_t mk_add(int x, int y, int z);
    plc_pkg::in_t it;
    it = '0;
    it.action = plc_pkg::ACT_ADD;
    it.point_x = clampc(x); it.point_y = clampc(y); it.point_z = clampc(z);
    it.read_index = SlotW'($urandom); it.read_part = PartW'($urandom);
    return it;
  endfunction

  function automatic plc_pkg::in_t mk_read(int idx, int part);
    plc_pkg::in_t it;
    it = '0;
    it.action = plc_pkg::ACT_READ;
    it.read_index = SlotW'(idx);
    it.read_part = PartW'(part);
    it.point_x = plc_pkg::coord_t'($urandom);
    it.point_y = plc_pkg::coord_t'($urandom);
    it.point_z = plc_pkg::coord_t'($urandom);
    return it;
  endfunction

  function automatic plc_pkg::in_t mk_raw();
    plc_pkg::in_t it;
    logic [63:0]  bits;
    bits = {$urandom, $urandom};
    it = bits[InW-1:0];
    it.point_x = plc_pkg::coord_t'($urandom);
    it.point_y = plc_pkg::coord_t'($urandom);
    it.point_z = plc_pkg::coord_t'($urandom);
    it.action = plc_pkg::action_e'($urandom_range(0, 3));
    return it;
  endfunction

  // frames of points around six centers, a new frame every 40 items, with reads and noise mixed in
  task automatic run_frames(int items, int spread);
    plc_pkg::in_t it;
    int  k, c;
    for (int i = 0; i < items; i++) begin
      if (i % 40 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
        for (c = 0; c < 6; c++) begin
          centers[c].x = plc_pkg::coord_t'(int'($urandom_range(0, 40000)) - 20000);
          centers[c].y = plc_pkg::coord_t'(int'($urandom_range(0, 40000)) - 20000);
          centers[c].z = plc_pkg::coord_t'(int'($urandom_range(0, 40000)) - 20000);
        end
        it = '0;
        it.action = plc_pkg::ACT_START;
        send(it);
      end
      k = $urandom_range(0, 99);
      if (k < 65) begin
        c = $urandom_range(0, 5);
        it = mk_add(int'($signed(centers[c].x)) + jit(spread),
                    int'($signed(centers[c].y)) + jit(spread),
                    int'($signed(centers[c].z)) + jit(spread));
      end else if (k < 75) begin
        it = mk_add($signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)));
      end else if (k < 92) begin
        it = mk_read($urandom_range(0, 63), $urandom_range(0, 7));
      end else begin
        it = mk_raw();
      end
      send(it);
    end
  endtask

  task automatic set_limits(logic [31:0] e, logic [31:0] c);
    drain();
    write_cfg(plc_pkg::CFG_EDGE_LIMIT, e);
    write_cfg(plc_pkg::CFG_CENTROID_LIMIT, c);
  endtask

  initial begin
    plc_pkg::in_t it;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: extremes, ties, every action and read part
    it = '0; it.action = plc_pkg::ACT_READ; send(it);
    send(mk_add(0, 0, 0));
    send(mk_add(32767, 32767, 32767));
    send(mk_add(-32768, -32768, -32768));
    send(mk_add(32767, -32768, 32767));
    send(mk_add(32767, 32767, -32768));
    send(mk_add(32767, 32767, 32767));
    send(mk_add(300, 0, 0));
    send(mk_add(-300, 0, 0));
    send(mk_add(0, 200, 500));
    for (int pt = 0; pt < 8; pt++) send(mk_read(0, pt));
    send(mk_read(1, plc_pkg::PART_LEFT));
    send(mk_read(63, plc_pkg::PART_MEAN));
    it = '0; it.action = plc_pkg::ACT_NONE; it.point_x = plc_pkg::coord_t'(-1); send(it);
    it = '0; it.action = plc_pkg::ACT_START; send(it);
    send(mk_read(1, plc_pkg::PART_MEAN));

    // long hold-off at the receiver while items keep coming
    hold_req = 1'b1;
    idle_on  = 1'b0;
    run_frames(40, 300);

    // nothing joins: the table fills up and drops points
    set_limits(32'd0, 32'd0);
    it = '0; it.action = plc_pkg::ACT_START; send(it);
    for (int i = 0; i < 70; i++) begin
      send(mk_add($signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom))));
    end
    send(mk_read(63, plc_pkg::PART_MEAN));
    run_frames(90, 300);
    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_frames(140, 2000);
    set_limits(32'd0, 32'd250000);
    run_frames(160, 800);
    set_limits(32'd1000000, 32'd0);
    run_frames(160, 800);
    set_limits($urandom_range(1, 3000000), $urandom_range(1, 3000000));
    run_frames(140, 1500);
    set_limits(32'd400000, 32'd400000);
    run_frames(100, 600);

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
